/* rtl/twap_pkg.sv */
// ============================================================================
// twap_pkg
// Shared types and constants for the sliding time window mean and peak block.
// ============================================================================
package twap_pkg;

	localparam int unsigned RING_DEPTH_DEF = 64;
	localparam int unsigned CFG_IDX_W      = 8;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_AVG_WIN  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PEAK_WIN = 8'd1;

	localparam logic [15:0] WIN_RESET = 16'd60;

	typedef struct packed {
		logic signed [31:0] sample_value;
		logic [31:0]        sample_time;
	} sample_t;

	typedef struct packed {
		logic signed [31:0] latest_value;
		logic signed [31:0] average_value;
		logic signed [31:0] peak_value;
		logic [6:0]         entries_held;
		logic               ring_overflow;
	} result_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;      // capture the input sample, drop oldest if full
		logic store;     // write sample into the ring
		logic prune_rd;  // read the entry at the front
		logic prune_pop; // drop the front entry
		logic scan_init; // clear accumulators and scan index
		logic scan_rd;   // read entry at scan index
		logic scan_acc;  // accumulate the entry read last cycle
		logic div_init;  // start the divider
		logic div_step;  // one restoring step
		logic out_load;  // capture the result
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic prune_hit; // front entry older than the prune threshold
		logic empty;     // nothing held
		logic scan_last; // scan index reaches the last held entry
		logic div_last;  // all divider steps done, quotient ready
	} status_t;

endpackage

/* rtl/twap_datapath.sv */
// ============================================================================
// twap_datapath
// Ring memory, pruning, window scan with sum and maximum, serial divider.
// ============================================================================
module twap_datapath import twap_pkg::*; #(
	parameter int unsigned RING_DEPTH = RING_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output status_t     stat,
	input  sample_t     sample,
	input  logic [15:0] avg_win_q,
	input  logic [15:0] peak_win_q,
	output result_t     result
);

	localparam int unsigned AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int unsigned CW = $clog2(RING_DEPTH + 1);
	localparam int unsigned SW = 32 + CW;
	localparam logic [CW-1:0] DEPTH_C = CW'(RING_DEPTH);

	logic [31:0] mem_val [RING_DEPTH];
	logic [31:0] mem_time [RING_DEPTH];
	logic [31:0] rd_val_q, rd_time_q;

	logic [AW-1:0] oldest_q;
	logic [CW-1:0] held_q;
	logic [CW-1:0] idx_q;
	logic          ovf_q;
	logic signed [31:0] v_q;
	logic [31:0]   t_q;
	logic signed [33:0] prune_from_q, avg_from_q, peak_from_q;
	logic signed [SW-1:0] sum_q;
	logic [CW-1:0] cnt_q;
	logic signed [31:0] peak_q;
	logic [SW-1:0] quo_q, rem_q;
	logic          neg_q;
	logic [$clog2(SW+1)-1:0] step_q;
	result_t       res_q;

	// slot arithmetic modulo the ring depth
	function automatic logic [AW-1:0] slot_add(logic [AW-1:0] s, logic [CW-1:0] n);
		logic [CW:0] r;
		r = (CW+1)'(s) + (CW+1)'(n);
		if (r >= (CW+1)'(RING_DEPTH))
			r = r - (CW+1)'(RING_DEPTH);
		return r[AW-1:0];
	endfunction

	logic [15:0] win_max;
	assign win_max = (avg_win_q > peak_win_q) ? avg_win_q : peak_win_q;

	logic [AW-1:0] rd_addr;
	always_comb begin
		rd_addr = oldest_q;
		if (cmd.scan_rd)
			rd_addr = slot_add(oldest_q, idx_q);
	end

	// memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.store) begin
			mem_val[slot_add(oldest_q, held_q)]  <= v_q;
			mem_time[slot_add(oldest_q, held_q)] <= t_q;
		end
		if (cmd.prune_rd || cmd.scan_rd) begin
			rd_val_q  <= mem_val[rd_addr];
			rd_time_q <= mem_time[rd_addr];
		end
	end

	logic signed [33:0] rd_t_s;
	assign rd_t_s = $signed({2'b00, rd_time_q});

	assign stat.prune_hit = rd_t_s < prune_from_q;
	assign stat.empty     = held_q == '0;
	assign stat.scan_last = idx_q == held_q - CW'(1);
	assign stat.div_last  = step_q == ($clog2(SW+1))'(SW);

	// divider magnitudes
	logic [SW-1:0] sum_mag, cnt_ext;
	logic [SW:0]   trial;
	assign sum_mag = sum_q[SW-1] ? SW'(-sum_q) : SW'(sum_q);
	assign cnt_ext = SW'(cnt_q);
	assign trial   = {rem_q, quo_q[SW-1]} - {1'b0, cnt_ext};

	// control state of the ring
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q <= '0;
			held_q   <= '0;
		end else begin
			if (cmd.load && held_q == DEPTH_C) begin
				oldest_q <= slot_add(oldest_q, CW'(1));
				held_q   <= held_q - CW'(1);
			end
			if (cmd.store)
				held_q <= held_q + CW'(1);
			if (cmd.prune_pop) begin
				oldest_q <= slot_add(oldest_q, CW'(1));
				held_q   <= held_q - CW'(1);
			end
		end
	end

	// sample capture, scan accumulators, divider
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			v_q   <= sample.sample_value;
			t_q   <= sample.sample_time;
			ovf_q <= held_q == DEPTH_C;
			prune_from_q <= $signed({2'b00, sample.sample_time}) -
				$signed({2'b00, win_max, 8'h00});
			avg_from_q   <= $signed({2'b00, sample.sample_time}) -
				$signed({2'b00, avg_win_q, 8'h00});
			peak_from_q  <= $signed({2'b00, sample.sample_time}) -
				$signed({2'b00, peak_win_q, 8'h00});
		end
		if (cmd.scan_init) begin
			idx_q  <= '0;
			sum_q  <= '0;
			cnt_q  <= '0;
			peak_q <= v_q;
		end
		if (cmd.scan_rd)
			idx_q <= idx_q + CW'(1);
		if (cmd.scan_acc) begin
			if (rd_t_s >= avg_from_q) begin
				sum_q <= sum_q + SW'($signed(rd_val_q));
				cnt_q <= cnt_q + CW'(1);
			end
			if (rd_t_s >= peak_from_q && $signed(rd_val_q) > peak_q)
				peak_q <= $signed(rd_val_q);
		end
		if (cmd.div_init) begin
			quo_q  <= sum_mag;
			rem_q  <= '0;
			neg_q  <= sum_q[SW-1];
			step_q <= '0;
		end
		if (cmd.div_step) begin
			step_q <= step_q + 1'b1;
			if (!trial[SW]) begin
				rem_q <= trial[SW-1:0];
				quo_q <= {quo_q[SW-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[SW-2:0], quo_q[SW-1]};
				quo_q <= {quo_q[SW-2:0], 1'b0};
			end
		end
		if (cmd.out_load) begin
			res_q.latest_value  <= v_q;
			res_q.average_value <= neg_q ? 32'(-quo_q) : quo_q[31:0];
			res_q.peak_value    <= peak_q;
			res_q.entries_held  <= 7'(held_q);
			res_q.ring_overflow <= ovf_q;
		end
	end

	assign result = res_q;

`ifndef NO_ASSERTIONS
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= DEPTH_C) else $error("held count above ring depth");
	a_store_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.store |-> held_q < DEPTH_C) else $error("store into full ring");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.prune_pop |-> held_q != '0) else $error("pop from empty ring");
`endif

endmodule

/* rtl/twap_ctrl.sv */
// ============================================================================
// twap_ctrl
// Sequencer: load, store, prune loop, window scan, divide, present result.
// ============================================================================
module twap_ctrl import twap_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	output logic    out_valid,
	input  logic    out_stall,
	output cmd_t    cmd,
	input  status_t stat
);

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_STORE = 8'b0000_0010,
		ST_PRD   = 8'b0000_0100,
		ST_PCHK  = 8'b0000_1000,
		ST_SCAN  = 8'b0001_0000,
		ST_LAST  = 8'b0010_0000,
		ST_DIV   = 8'b0100_0000,
		ST_DONE  = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;
	logic   scan_prev_q;

	// the output register may be refilled once the old result is taken
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = state_q != ST_IDLE;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_STORE;
				end
			end
			ST_STORE: begin
				cmd.store = 1'b1;
				state_d   = ST_PRD;
			end
			ST_PRD: begin
				cmd.prune_rd = 1'b1;
				state_d      = ST_PCHK;
			end
			ST_PCHK: begin
				if (stat.prune_hit && !stat.empty) begin
					cmd.prune_pop = 1'b1;
					state_d       = ST_PRD;
				end else begin
					cmd.scan_init = 1'b1;
					state_d       = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan_rd  = 1'b1;
				// accumulate the entry read in the previous scan cycle
				cmd.scan_acc = scan_prev_q;
				if (stat.scan_last)
					state_d = ST_LAST;
			end
			ST_LAST: begin
				cmd.scan_acc = 1'b1;
				state_d      = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_init = 1'b1;
				state_d      = ST_DONE;
			end
			ST_DONE: begin
				if (!stat.div_last)
					cmd.div_step = 1'b1;
				else if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			scan_prev_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			scan_prev_q <= cmd.scan_rd;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

`ifndef NO_ASSERTIONS
	a_state_hot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q)) else $error("state not one-hot");
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> state_q == ST_IDLE) else $error("load outside idle");
	a_out_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid_q) else $error("result lost");
`endif

endmodule

/* rtl/time_window_average_peak.sv */
// Sequence per sample: load, store, a read and check of the front entry for each of
// P pruned entries, a serial scan of the H entries held after pruning, then SW =
// 32 + clog2(RING_DEPTH+1) restoring divider steps. in_stall holds the next sample
// off until the result is loaded, which waits while an unread result is stalled.
// Reset: async; ring empties, windows = 60 (x 256 time units), ring memory not cleared.
// ============================================================================
// time_window_average_peak
// Sliding time window mean and maximum over a ring of timestamped samples.
// ============================================================================
module time_window_average_peak import twap_pkg::*; #(
	parameter int unsigned RING_DEPTH = RING_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  sample_t              in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output result_t              out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data
);

	cmd_t        cmd;
	status_t     stat;
	logic [15:0] avg_win_q, peak_win_q;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_win_q  <= WIN_RESET;
			peak_win_q <= WIN_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_AVG_WIN:  avg_win_q  <= cfg_data[15:0];
				REG_PEAK_WIN: peak_win_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	twap_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.stat      (stat)
	);

	twap_datapath #(.RING_DEPTH(RING_DEPTH)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.sample     (in_data),
		.avg_win_q  (avg_win_q),
		.peak_win_q (peak_win_q),
		.result     (out_data)
	);

endmodule
